### hw/rtl/rtmp_cd_pkg.sv
// Shared types, constants and helpers for the RTMP chunk stream deframer.
package rtmp_cd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CSID_W = 17;
    localparam int unsigned LEN_W  = 24;
    localparam int unsigned MSID_W = 32;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned HCNT_W = 4;

    localparam logic [LEN_W-1:0] MAX24           = 24'hFF_FFFF;
    localparam logic [LEN_W-1:0] INIT_CHUNK_SIZE = 24'd128;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EXT_TS = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MID    = 2'd2;

    // Chunk header formats
    localparam logic [1:0] FMT_0 = 2'd0;
    localparam logic [1:0] FMT_1 = 2'd1;
    localparam logic [1:0] FMT_2 = 2'd2;
    localparam logic [1:0] FMT_3 = 2'd3;

    // Basic header stream id escapes
    localparam logic [5:0] CSID_ESC_1B = 6'd0;
    localparam logic [5:0] CSID_ESC_2B = 6'd1;

    // Message header byte positions
    localparam logic [HCNT_W-1:0] HB_LEN0  = 4'd3;
    localparam logic [HCNT_W-1:0] HB_TYPE  = 4'd6;
    localparam logic [HCNT_W-1:0] HB_MS0   = 4'd7;
    localparam logic [HCNT_W-1:0] HB_MS1   = 4'd8;
    localparam logic [HCNT_W-1:0] HB_MS2   = 4'd9;
    localparam logic [HCNT_W-1:0] HB_MS3   = 4'd10;
    localparam logic [HCNT_W-1:0] HLEN_F0  = 4'd11;
    localparam logic [HCNT_W-1:0] HLEN_F1  = 4'd7;
    localparam logic [HCNT_W-1:0] HLEN_F2  = 4'd3;

    // Set-chunk-size control message
    localparam logic [BYTE_W-1:0] TYPE_SET_CHUNK = 8'd1;
    localparam logic [CSID_W-1:0] CSID_CONTROL   = 17'd2;
    localparam logic [CSID_W-1:0] CSID_OFFSET    = 17'd64;

    typedef enum logic [2:0] {
        PH_BASIC   = 3'd0,
        PH_ID1     = 3'd1,
        PH_ID2A    = 3'd2,
        PH_ID2B    = 3'd3,
        PH_MSGHDR  = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [CSID_W-1:0] chunk_stream_id;
        logic [BYTE_W-1:0] msg_type_id;
        logic [MSID_W-1:0] msg_stream_id;
        logic [LEN_W-1:0]  msg_length;
        logic [LEN_W-1:0]  timestamp_field;
        logic              last_of_message;
        logic [ERR_W-1:0]  error_code;
    } t_result;

    // Chunk size limited to 1..MAX24
    function automatic logic [LEN_W-1:0] clamp_size(input logic [MSID_W-1:0] v);
        logic [LEN_W-1:0] s;
        if (v > {8'd0, MAX24}) begin
            s = MAX24;
        end else if (v == '0) begin
            s = 24'd1;
        end else begin
            s = v[LEN_W-1:0];
        end
        return s;
    endfunction

endpackage

### hw/rtl/rtmp_cd_ifs.sv
// Valid/ready stream interfaces for received bytes and deframed results.
interface rtmp_cd_byte_if;
    logic                           valid;
    logic                           ready;
    logic [rtmp_cd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rtmp_cd_result_if;
    logic                           valid;
    logic                           ready;
    logic [rtmp_cd_pkg::KIND_W-1:0] out_kind;
    logic [rtmp_cd_pkg::BYTE_W-1:0] payload_byte;
    logic [rtmp_cd_pkg::CSID_W-1:0] chunk_stream_id;
    logic [rtmp_cd_pkg::BYTE_W-1:0] msg_type_id;
    logic [rtmp_cd_pkg::MSID_W-1:0] msg_stream_id;
    logic [rtmp_cd_pkg::LEN_W-1:0]  msg_length;
    logic [rtmp_cd_pkg::LEN_W-1:0]  timestamp_field;
    logic                           last_of_message;
    logic [rtmp_cd_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output out_kind, output payload_byte,
                    output chunk_stream_id, output msg_type_id, output msg_stream_id,
                    output msg_length, output timestamp_field, output last_of_message,
                    output error_code, input ready);
    modport sink   (input valid, input out_kind, input payload_byte,
                    input chunk_stream_id, input msg_type_id, input msg_stream_id,
                    input msg_length, input timestamp_field, input last_of_message,
                    input error_code, output ready);
endinterface

### hw/rtl/rtmp_chunk_deframer.sv
// Top level of the RTMP chunk stream deframer: input register, parser, result register.
//
//  channel   | dir | carries                                    | accepted when
//  i_rx      | in  | rx_byte                                    | valid && ready
//  o_res     | out | kind, byte, ids, type, length, ts, last, err | valid && ready
//  i_cfg_wr  | in  | initial_chunk_size (24 bit)                | i_cfg_wr_en high
//
//  One byte per cycle while the result side is not stalled: a byte waits in the input register,
//  goes through the parser and its result lands in the result register.
//  A stalled result holds the result register; the input register still takes one byte.
//  Synchronous active-low reset; chunk size returns to 128.
module rtmp_chunk_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rtmp_cd_pkg::LEN_W-1:0] i_cfg_wr_data,
    rtmp_cd_byte_if.sink                  i_rx,
    rtmp_cd_result_if.source              o_res
);

    logic                           r_in_valid;
    logic [rtmp_cd_pkg::BYTE_W-1:0] r_in_byte;
    logic                           r_out_valid;
    rtmp_cd_pkg::t_result           r_out;
    logic                           w_advance;
    logic                           w_res_valid;
    rtmp_cd_pkg::t_result           w_res;

    // Parser takes the held byte when the result slot is free or draining
    assign w_advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    rtmp_cd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_advance),
        .i_byte        (r_in_byte),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    // Drive the result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.out_kind        = r_out.out_kind;
    assign o_res.payload_byte    = r_out.payload_byte;
    assign o_res.chunk_stream_id = r_out.chunk_stream_id;
    assign o_res.msg_type_id     = r_out.msg_type_id;
    assign o_res.msg_stream_id   = r_out.msg_stream_id;
    assign o_res.msg_length      = r_out.msg_length;
    assign o_res.timestamp_field = r_out.timestamp_field;
    assign o_res.last_of_message = r_out.last_of_message;
    assign o_res.error_code      = r_out.error_code;

    // A held byte that cannot advance stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");

    // Parser never fires into an occupied, stalled result slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !w_advance)
        else $error("result register overwritten while stalled");

    // Error results carry a code and never end a message; others carry none
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.out_kind == rtmp_cd_pkg::KIND_ERROR)
                         == (o_res.error_code != rtmp_cd_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

endmodule

### hw/rtl/rtmp_cd_parser.sv
// Per-byte chunk header / payload parser holding the single message context.
module rtmp_cd_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rtmp_cd_pkg::LEN_W-1:0]  i_cfg_wr_data,
    input  logic                           i_step,
    input  logic [rtmp_cd_pkg::BYTE_W-1:0] i_byte,
    output logic                           o_res_valid,
    output rtmp_cd_pkg::t_result           o_res
);

    rtmp_cd_pkg::t_phase r_phase, n_phase;
    logic [rtmp_cd_pkg::HCNT_W-1:0] r_hcnt, n_hcnt;
    logic [1:0]                     r_fmt, n_fmt;
    logic [rtmp_cd_pkg::CSID_W-1:0] r_cs, n_cs;
    logic [rtmp_cd_pkg::LEN_W-1:0]  r_ts, n_ts;
    logic [rtmp_cd_pkg::LEN_W-1:0]  r_len, n_len;
    logic [rtmp_cd_pkg::BYTE_W-1:0] r_type, n_type;
    logic [rtmp_cd_pkg::MSID_W-1:0] r_ms, n_ms;
    logic [rtmp_cd_pkg::LEN_W-1:0]  r_bd, n_bd;
    logic [rtmp_cd_pkg::LEN_W-1:0]  r_cl, n_cl;
    logic [rtmp_cd_pkg::LEN_W-1:0]  r_active, n_active;
    logic [rtmp_cd_pkg::MSID_W-1:0] r_lw, n_lw;
    logic                           r_halted, n_halted;

    // Values after this byte is captured
    logic [rtmp_cd_pkg::HCNT_W-1:0] c_hcnt;
    logic [1:0]                     c_fmt;
    logic [rtmp_cd_pkg::CSID_W-1:0] c_cs;
    logic [rtmp_cd_pkg::LEN_W-1:0]  c_ts;
    logic [rtmp_cd_pkg::LEN_W-1:0]  c_len;
    logic [rtmp_cd_pkg::BYTE_W-1:0] c_type;
    logic [rtmp_cd_pkg::MSID_W-1:0] c_ms;
    logic [rtmp_cd_pkg::LEN_W-1:0]  c_bd;
    logic [rtmp_cd_pkg::LEN_W-1:0]  c_cl;
    logic [rtmp_cd_pkg::MSID_W-1:0] c_lw;

    logic                           w_basic_end;
    logic                           w_hdr_end;
    logic                           w_err_mid;
    logic                           w_err_ext;
    logic                           w_start;
    logic                           w_empty;
    logic                           w_pay;
    logic                           w_pay_last;
    logic                           w_pay_chunk_end;
    logic                           w_finish;
    logic                           w_set_size;
    logic                           w_go;
    logic [rtmp_cd_pkg::LEN_W-1:0]  w_remaining;
    logic [rtmp_cd_pkg::LEN_W-1:0]  w_chunk_len;

    assign w_go = i_step && !r_halted;

    // Byte capture into header fields and payload counters
    always_comb begin
        c_hcnt = r_hcnt;
        c_fmt  = r_fmt;
        c_cs   = r_cs;
        c_ts   = r_ts;
        c_len  = r_len;
        c_type = r_type;
        c_ms   = r_ms;
        c_bd   = r_bd;
        c_cl   = r_cl;
        c_lw   = r_lw;
        unique case (r_phase)
            rtmp_cd_pkg::PH_BASIC: begin
                c_fmt = i_byte[7:6];
                c_cs  = {11'd0, i_byte[5:0]};
            end
            rtmp_cd_pkg::PH_ID1: begin
                c_cs = {9'd0, i_byte} + rtmp_cd_pkg::CSID_OFFSET;
            end
            rtmp_cd_pkg::PH_ID2A: begin
                c_cs = {9'd0, i_byte};
            end
            rtmp_cd_pkg::PH_ID2B: begin
                c_cs = r_cs + {1'b0, i_byte, 8'd0} + rtmp_cd_pkg::CSID_OFFSET;
            end
            rtmp_cd_pkg::PH_MSGHDR: begin
                if (r_hcnt < rtmp_cd_pkg::HB_LEN0) begin
                    c_ts = {r_ts[15:0], i_byte};
                end else if (r_hcnt < rtmp_cd_pkg::HB_TYPE) begin
                    c_len = {r_len[15:0], i_byte};
                end else if (r_hcnt == rtmp_cd_pkg::HB_TYPE) begin
                    c_type = i_byte;
                end else if (r_hcnt == rtmp_cd_pkg::HB_MS0) begin
                    c_ms = {24'd0, i_byte};
                end else if (r_hcnt == rtmp_cd_pkg::HB_MS1) begin
                    c_ms = r_ms | {16'd0, i_byte, 8'd0};
                end else if (r_hcnt == rtmp_cd_pkg::HB_MS2) begin
                    c_ms = r_ms | {8'd0, i_byte, 16'd0};
                end else if (r_hcnt == rtmp_cd_pkg::HB_MS3) begin
                    c_ms = r_ms | {i_byte, 24'd0};
                end
                c_hcnt = r_hcnt + 4'd1;
            end
            rtmp_cd_pkg::PH_PAYLOAD: begin
                // first four payload bytes, big-endian
                if (r_bd == 24'd0) begin
                    c_lw = {i_byte, 24'd0};
                end else if (r_bd == 24'd1) begin
                    c_lw = r_lw | {8'd0, i_byte, 16'd0};
                end else if (r_bd == 24'd2) begin
                    c_lw = r_lw | {16'd0, i_byte, 8'd0};
                end else if (r_bd == 24'd3) begin
                    c_lw = r_lw | {24'd0, i_byte};
                end
                c_bd = r_bd + 24'd1;
                c_cl = (r_cl != 24'd0) ? r_cl - 24'd1 : 24'd0;
            end
            default: begin
            end
        endcase
    end

    // Events of this byte
    assign w_basic_end = ((r_phase == rtmp_cd_pkg::PH_BASIC)
                          && (i_byte[5:0] != rtmp_cd_pkg::CSID_ESC_1B)
                          && (i_byte[5:0] != rtmp_cd_pkg::CSID_ESC_2B))
                         || (r_phase == rtmp_cd_pkg::PH_ID1)
                         || (r_phase == rtmp_cd_pkg::PH_ID2B);
    assign w_hdr_end = (r_phase == rtmp_cd_pkg::PH_MSGHDR)
                       && (((r_fmt == rtmp_cd_pkg::FMT_0) && (c_hcnt >= rtmp_cd_pkg::HLEN_F0))
                        || ((r_fmt == rtmp_cd_pkg::FMT_1) && (c_hcnt >= rtmp_cd_pkg::HLEN_F1))
                        || ((r_fmt == rtmp_cd_pkg::FMT_2) && (c_hcnt >= rtmp_cd_pkg::HLEN_F2))
                        || (r_fmt == rtmp_cd_pkg::FMT_3));
    assign w_err_mid = w_hdr_end && (r_fmt <= rtmp_cd_pkg::FMT_1) && (r_bd != 24'd0);
    assign w_err_ext = w_hdr_end && !w_err_mid && (r_fmt <= rtmp_cd_pkg::FMT_2)
                       && (c_ts == rtmp_cd_pkg::MAX24);
    assign w_start = (w_basic_end && (c_fmt == rtmp_cd_pkg::FMT_3))
                     || (w_hdr_end && !w_err_mid && !w_err_ext);
    assign w_remaining = (c_len > r_bd) ? c_len - r_bd : 24'd0;
    assign w_chunk_len = (w_remaining < r_active) ? w_remaining : r_active;
    assign w_empty = w_start && (w_remaining == 24'd0);
    assign w_pay = (r_phase == rtmp_cd_pkg::PH_PAYLOAD);
    assign w_pay_last = w_pay && (c_bd >= c_len);
    assign w_pay_chunk_end = w_pay && !w_pay_last && (c_cl == 24'd0);
    assign w_finish = w_empty || w_pay_last;
    assign w_set_size = w_finish && (c_type == rtmp_cd_pkg::TYPE_SET_CHUNK)
                        && (c_cs == rtmp_cd_pkg::CSID_CONTROL) && (c_ms == '0);

    // Next context and counters
    always_comb begin
        n_fmt    = c_fmt;
        n_cs     = c_cs;
        n_ts     = c_ts;
        n_len    = c_len;
        n_type   = c_type;
        n_ms     = c_ms;
        n_lw     = c_lw;
        n_hcnt   = w_basic_end ? '0 : c_hcnt;
        n_bd     = w_finish ? '0 : c_bd;
        n_cl     = (w_start && !w_empty) ? w_chunk_len : c_cl;
        n_halted = w_err_mid || w_err_ext;
        n_active = w_set_size ? rtmp_cd_pkg::clamp_size(c_lw) : r_active;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            rtmp_cd_pkg::PH_BASIC: begin
                if (i_byte[5:0] == rtmp_cd_pkg::CSID_ESC_1B) begin
                    n_phase = rtmp_cd_pkg::PH_ID1;
                end else if (i_byte[5:0] == rtmp_cd_pkg::CSID_ESC_2B) begin
                    n_phase = rtmp_cd_pkg::PH_ID2A;
                end else if (c_fmt != rtmp_cd_pkg::FMT_3) begin
                    n_phase = rtmp_cd_pkg::PH_MSGHDR;
                end else begin
                    n_phase = w_empty ? rtmp_cd_pkg::PH_BASIC : rtmp_cd_pkg::PH_PAYLOAD;
                end
            end
            rtmp_cd_pkg::PH_ID1, rtmp_cd_pkg::PH_ID2B: begin
                if (c_fmt != rtmp_cd_pkg::FMT_3) begin
                    n_phase = rtmp_cd_pkg::PH_MSGHDR;
                end else begin
                    n_phase = w_empty ? rtmp_cd_pkg::PH_BASIC : rtmp_cd_pkg::PH_PAYLOAD;
                end
            end
            rtmp_cd_pkg::PH_ID2A: begin
                n_phase = rtmp_cd_pkg::PH_ID2B;
            end
            rtmp_cd_pkg::PH_MSGHDR: begin
                if (w_start) begin
                    n_phase = w_empty ? rtmp_cd_pkg::PH_BASIC : rtmp_cd_pkg::PH_PAYLOAD;
                end
            end
            rtmp_cd_pkg::PH_PAYLOAD: begin
                if (w_pay_last || w_pay_chunk_end) begin
                    n_phase = rtmp_cd_pkg::PH_BASIC;
                end
            end
            default: begin
                n_phase = rtmp_cd_pkg::PH_BASIC;
            end
        endcase
    end

    // Result of this byte, tagged with the updated context
    always_comb begin
        o_res_valid = w_go && (w_pay || w_empty || w_err_mid || w_err_ext);
        o_res.payload_byte    = w_pay ? i_byte : '0;
        o_res.chunk_stream_id = c_cs;
        o_res.msg_type_id     = c_type;
        o_res.msg_stream_id   = c_ms;
        o_res.msg_length      = c_len;
        o_res.timestamp_field = c_ts;
        if (w_err_mid) begin
            o_res.out_kind        = rtmp_cd_pkg::KIND_ERROR;
            o_res.error_code      = rtmp_cd_pkg::ERR_MID;
            o_res.last_of_message = 1'b0;
        end else if (w_err_ext) begin
            o_res.out_kind        = rtmp_cd_pkg::KIND_ERROR;
            o_res.error_code      = rtmp_cd_pkg::ERR_EXT_TS;
            o_res.last_of_message = 1'b0;
        end else if (w_empty) begin
            o_res.out_kind        = rtmp_cd_pkg::KIND_EMPTY;
            o_res.error_code      = rtmp_cd_pkg::ERR_NONE;
            o_res.last_of_message = 1'b1;
        end else begin
            o_res.out_kind        = rtmp_cd_pkg::KIND_PAYLOAD;
            o_res.error_code      = rtmp_cd_pkg::ERR_NONE;
            o_res.last_of_message = w_pay_last;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rtmp_cd_pkg::PH_BASIC;
            r_hcnt   <= '0;
            r_fmt    <= '0;
            r_cs     <= '0;
            r_ts     <= '0;
            r_len    <= '0;
            r_type   <= '0;
            r_ms     <= '0;
            r_bd     <= '0;
            r_cl     <= '0;
            r_active <= rtmp_cd_pkg::INIT_CHUNK_SIZE;
            r_lw     <= '0;
            r_halted <= 1'b0;
        end else begin
            if (w_go) begin
                r_phase  <= n_phase;
                r_hcnt   <= n_hcnt;
                r_fmt    <= n_fmt;
                r_cs     <= n_cs;
                r_ts     <= n_ts;
                r_len    <= n_len;
                r_type   <= n_type;
                r_ms     <= n_ms;
                r_bd     <= n_bd;
                r_cl     <= n_cl;
                r_lw     <= n_lw;
                r_halted <= n_halted;
            end
            if (i_cfg_wr_en) begin
                r_active <= rtmp_cd_pkg::clamp_size({8'd0, i_cfg_wr_data});
            end else if (w_go) begin
                r_active <= n_active;
            end
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("parser left halt without reset");

    // No results come out of a halted parser
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_res_valid)
        else $error("result produced while halted");

    // Chunk size never drops to zero
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active != '0)
        else $error("active chunk size is zero");

    // An error result always halts the parser
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.out_kind == rtmp_cd_pkg::KIND_ERROR)) |=> r_halted)
        else $error("error result without halt");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for rtmp_chunk_deframer: chunked message stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

import rtmp_cd_pkg::*;

// Follows the deframer context byte by byte and holds the results still to come
class deframe_board;
    t_phase              phase;
    logic [HCNT_W-1:0]   hdr_cnt;
    logic [1:0]          fmt;
    logic [CSID_W-1:0]   csid;
    logic [LEN_W-1:0]    stamp;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    got_bytes;
    logic [LEN_W-1:0]    left;
    logic [LEN_W-1:0]    chunk_size;
    logic [BYTE_W-1:0]   mtype;
    logic [MSID_W-1:0]   msid;
    logic [MSID_W-1:0]   lead_word;
    bit                  halted;
    t_result             due[$];
    int unsigned         n_bytes;
    int unsigned         n_payload;
    int unsigned         n_marker;
    int unsigned         n_error;
    int unsigned         n_resize;
    int unsigned         fails;

    function new();
        phase      = PH_BASIC;
        hdr_cnt    = '0;
        fmt        = FMT_0;
        csid       = '0;
        stamp      = '0;
        len        = '0;
        got_bytes  = '0;
        left       = '0;
        chunk_size = INIT_CHUNK_SIZE;
        mtype      = '0;
        msid       = '0;
        lead_word  = '0;
        halted     = 1'b0;
    endfunction

    // register write takes effect at once; zero acts as one
    function void load_size(logic [LEN_W-1:0] v);
        chunk_size = (v == '0) ? 24'd1 : v;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data, logic last,
                       logic [ERR_W-1:0] code);
        t_result r;
        r.out_kind        = kind;
        r.payload_byte    = data;
        r.chunk_stream_id = csid;
        r.msg_type_id     = mtype;
        r.msg_stream_id   = msid;
        r.msg_length      = len;
        r.timestamp_field = stamp;
        r.last_of_message = last;
        r.error_code      = code;
        due.push_back(r);
        if (kind == KIND_PAYLOAD) n_payload++;
        else if (kind == KIND_EMPTY) n_marker++;
        else n_error++;
    endfunction

    // end of message: a control message on stream 2 may set a new chunk size
    function void message_done();
        if (mtype == TYPE_SET_CHUNK && csid == CSID_CONTROL && msid == '0) begin
            if (lead_word > {8'd0, MAX24}) chunk_size = MAX24;
            else if (lead_word == '0) chunk_size = 24'd1;
            else chunk_size = lead_word[LEN_W-1:0];
            n_resize++;
        end
        got_bytes = '0;
        phase     = PH_BASIC;
    endfunction

    function void start_chunk();
        logic [LEN_W-1:0] remaining;
        remaining = (len > got_bytes) ? len - got_bytes : '0;
        if (remaining == '0) begin
            push(KIND_EMPTY, 8'd0, 1'b1, ERR_NONE);
            message_done();
        end else begin
            left  = (remaining < chunk_size) ? remaining : chunk_size;
            phase = PH_PAYLOAD;
        end
    endfunction

    // mid-message check wins over the extended timestamp check
    function void header_done();
        if (fmt <= FMT_1 && got_bytes != '0) begin
            push(KIND_ERROR, 8'd0, 1'b0, ERR_MID);
            halted = 1'b1;
        end else if (stamp == MAX24) begin
            push(KIND_ERROR, 8'd0, 1'b0, ERR_EXT_TS);
            halted = 1'b1;
        end else begin
            start_chunk();
        end
    endfunction

    function void basic_done();
        hdr_cnt = '0;
        if (fmt == FMT_3) start_chunk();
        else phase = PH_MSGHDR;
    endfunction

    // one accepted byte request
    function void note_byte(logic [BYTE_W-1:0] b);
        logic [HCNT_W-1:0] n;
        n_bytes++;
        if (halted) return;
        case (phase)
            PH_BASIC: begin
                fmt  = b[7:6];
                csid = {11'd0, b[5:0]};
                if (b[5:0] == CSID_ESC_1B) phase = PH_ID1;
                else if (b[5:0] == CSID_ESC_2B) phase = PH_ID2A;
                else basic_done();
            end
            PH_ID1: begin
                csid = CSID_OFFSET + b;
                basic_done();
            end
            PH_ID2A: begin
                csid  = {9'd0, b};
                phase = PH_ID2B;
            end
            PH_ID2B: begin
                csid = csid + {b, 8'd0} + CSID_OFFSET;
                basic_done();
            end
            PH_MSGHDR: begin
                n = hdr_cnt;
                if (n < HB_LEN0) begin
                    stamp = {stamp[15:0], b};
                end else if (n < HB_TYPE) begin
                    len = {len[15:0], b};
                end else if (n == HB_TYPE) begin
                    mtype = b;
                end else if (n <= HB_MS3) begin
                    if (n == HB_MS0) msid = '0;
                    msid = msid | ({24'd0, b} << (8 * (n - HB_MS0)));
                end
                n       = n + 1'b1;
                hdr_cnt = n;
                if ((fmt == FMT_0 && n >= HLEN_F0) || (fmt == FMT_1 && n >= HLEN_F1) ||
                    (fmt == FMT_2 && n >= HLEN_F2)) header_done();
            end
            PH_PAYLOAD: begin
                if (got_bytes == '0) lead_word = {b, 24'd0};
                else if (got_bytes < 4) lead_word = lead_word | ({24'd0, b} << (24 - 8 * got_bytes));
                got_bytes = got_bytes + 1'b1;
                if (left > 0) left = left - 1'b1;
                if (got_bytes >= len) begin
                    push(KIND_PAYLOAD, b, 1'b1, ERR_NONE);
                    message_done();
                end else begin
                    push(KIND_PAYLOAD, b, 1'b0, ERR_NONE);
                    if (left == '0) phase = PH_BASIC;
                end
            end
            default: phase = PH_BASIC;
        endcase
    endfunction

    function string describe(t_result r);
        return $sformatf("kind=%0d byte=%02h cs=%0d type=%02h ms=%08h len=%0d ts=%06h last=%0b err=%0d",
                         r.out_kind, r.payload_byte, r.chunk_stream_id, r.msg_type_id,
                         r.msg_stream_id, r.msg_length, r.timestamp_field, r.last_of_message,
                         r.error_code);
    endfunction

    // compare one delivered result against the oldest one predicted
    function void check_result(t_result got);
        t_result want;
        string   diffs;
        if (due.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result: %s", describe(got));
            return;
        end
        want  = due.pop_front();
        diffs = "";
        if (got.out_kind !== want.out_kind) diffs = {diffs, " kind"};
        if (got.payload_byte !== want.payload_byte) diffs = {diffs, " byte"};
        if (got.chunk_stream_id !== want.chunk_stream_id) diffs = {diffs, " chunk_stream"};
        if (got.msg_type_id !== want.msg_type_id) diffs = {diffs, " type"};
        if (got.msg_stream_id !== want.msg_stream_id) diffs = {diffs, " msg_stream"};
        if (got.msg_length !== want.msg_length) diffs = {diffs, " length"};
        if (got.timestamp_field !== want.timestamp_field) diffs = {diffs, " timestamp"};
        if (got.last_of_message !== want.last_of_message) diffs = {diffs, " last"};
        if (got.error_code !== want.error_code) diffs = {diffs, " error"};
        if (diffs != "") begin
            fails++;
            if (fails <= 10) begin
                $display("mismatch on%s", diffs);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction
endclass

module tb_top;
    localparam int unsigned ITEMS     = 1850;
    localparam int unsigned PHASE_LEN = 170;
    localparam int unsigned HOLD_AT   = 400;
    localparam int unsigned HOLD_LEN  = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;

    rtmp_cd_byte_if   rx_bus ();
    rtmp_cd_result_if res_bus ();

    deframe_board sb = new();
    bit           calm;
    bit           held;
    int unsigned  cfg_writes;

    rtmp_chunk_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx          (rx_bus),
        .o_res         (res_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // result side: random back-pressure and one long hold
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.n_bytes >= HOLD_AT) begin
                held = 1'b1;
                res_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            res_bus.ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            sb.check_result({res_bus.out_kind, res_bus.payload_byte, res_bus.chunk_stream_id,
                             res_bus.msg_type_id, res_bus.msg_stream_id, res_bus.msg_length,
                             res_bus.timestamp_field, res_bus.last_of_message,
                             res_bus.error_code});
        end
    end

    // drive one byte request and wait until the deframer takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < 17) begin
            rx_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // basic header plus the message header of the given format
    task automatic send_header(input logic [1:0] f, input int unsigned id, input bit wide,
                               input logic [LEN_W-1:0] ts, input logic [LEN_W-1:0] mlen,
                               input logic [BYTE_W-1:0] ty, input logic [MSID_W-1:0] ms);
        logic [CSID_W-1:0] idv;
        logic [15:0]       ofs;
        int                k;
        idv = id;
        ofs = idv - CSID_OFFSET;
        if (idv < 64) begin
            send_byte({f, idv[5:0]});
        end else if (idv < 320 && !wide) begin
            send_byte({f, CSID_ESC_1B});
            send_byte(ofs[7:0]);
        end else begin
            send_byte({f, CSID_ESC_2B});
            send_byte(ofs[7:0]);
            send_byte(ofs[15:8]);
        end
        if (f != FMT_3) for (k = 2; k >= 0; k--) send_byte(ts[8*k +: 8]);
        if (f <= FMT_1) begin
            for (k = 2; k >= 0; k--) send_byte(mlen[8*k +: 8]);
            send_byte(ty);
        end
        if (f == FMT_0) for (k = 0; k < 4; k++) send_byte(ms[8*k +: 8]);
    endtask

    // never the extended timestamp marker
    function automatic logic [LEN_W-1:0] pick_stamp();
        logic [LEN_W-1:0] s;
        case ($urandom_range(3))
            0: s = '0;
            1: s = MAX24 - 24'd1;
            default: begin
                s = $urandom;
                if (s == MAX24) s = s - 24'd1;
            end
        endcase
        return s;
    endfunction

    function automatic int unsigned pick_csid();
        int unsigned ext[5] = '{2, 63, 64, 319, 65599};
        case ($urandom_range(3))
            0: return $urandom_range(63, 2);
            1: return $urandom_range(319, 64);
            2: return $urandom_range(65599, 320);
            default: return ext[$urandom_range(4)];
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 80) return $urandom_range(24, 1);
        return $urandom_range(160, 25);
    endfunction

    // one whole message, split at the chunk size, continuation headers between chunks
    task automatic send_random_message();
        logic [1:0]        f;
        int unsigned       id, roll, total, chunk, sent, k;
        bit                wide;
        logic [LEN_W-1:0]  mlen;
        logic [BYTE_W-1:0] ty, pb;
        logic [MSID_W-1:0] ms, word;
        roll = $urandom_range(99);
        wide = $urandom_range(1);
        word = $urandom;
        ty   = $urandom;
        ms   = ($urandom_range(3) == 0) ? '0 : $urandom;
        if (roll < 15) begin
            // set-chunk-size control message, sometimes short or long
            f    = FMT_0;
            id   = CSID_CONTROL;
            ty   = TYPE_SET_CHUNK;
            ms   = '0;
            mlen = ($urandom_range(3) == 0) ? $urandom_range(7, 0) : 4;
            case ($urandom_range(4))
                0: word = '0;
                1: word = '1;
                2: word = 32'h0100_0000;
                3: word = 32'h00FF_FFFF;
                default: word = $urandom_range(40, 1);
            endcase
        end else begin
            f    = (roll < 55) ? FMT_0 : (roll < 75) ? FMT_1 : (roll < 88) ? FMT_2 : FMT_3;
            id   = pick_csid();
            mlen = pick_len();
        end
        total = (f <= FMT_1) ? mlen : sb.len;
        send_header(f, id, wide, pick_stamp(), mlen, ty, ms);
        sent = 0;
        while (sent < total) begin
            chunk = total - sent;
            if (chunk > sb.chunk_size) chunk = sb.chunk_size;
            for (k = 0; k < chunk; k++) begin
                if (sent + k < 4) pb = word[31 - 8*(sent + k) -: 8];
                else pb = $urandom;
                send_byte(pb);
            end
            sent += chunk;
            if (sent < total) begin
                if ($urandom_range(4) == 0) begin
                    send_header(FMT_2, pick_csid(), wide, pick_stamp(), '0, '0, '0);
                end else begin
                    send_header(FMT_3, ($urandom_range(2) == 0) ? pick_csid() : id, wide,
                                '0, '0, '0, '0);
                end
            end
        end
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        int unsigned guard;
        guard = 0;
        rx_bus.valid <= 1'b0;
        while (sb.due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_chunk_size(input logic [LEN_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.load_size(v);
        cfg_writes++;
    endtask

    // ends in an error, after which the block ignores everything
    task automatic halt_block();
        int unsigned k;
        write_chunk_size(24'd1);
        case ($urandom_range(3))
            0: send_header(FMT_0, pick_csid(), 1'b0, MAX24, pick_len(), 8'($urandom), $urandom);
            1: send_header(FMT_2, pick_csid(), 1'b1, MAX24, '0, '0, '0);
            default: begin
                // one-byte chunk leaves the message open, then a new length header
                send_header(FMT_0, 5, 1'b0, 24'd7, 24'd3, 8'd9, 32'd1);
                send_byte($urandom);
                send_header($urandom_range(1) ? FMT_0 : FMT_1, 5, 1'b0,
                            $urandom_range(1) ? MAX24 : 24'd100, 24'd2, 8'd0, '0);
            end
        endcase
        for (k = 0; k < 12; k++) send_byte($urandom);
    endtask

    initial begin
        int unsigned      phase_no;
        int unsigned      stop_at;
        logic [LEN_W-1:0] size_pick;
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: id forms at their extremes, empty messages, default chunk size
        send_header(FMT_0, 63, 1'b0, MAX24 - 24'd1, 24'd0, 8'hFF, 32'hFFFF_FFFF);
        send_header(FMT_3, 319, 1'b0, '0, '0, '0, '0);
        send_header(FMT_2, 65599, 1'b1, 24'd0, '0, '0, '0);
        send_header(FMT_1, 64, 1'b1, 24'h01_0203, 24'd2, 8'h00, '0);
        send_byte(8'h00);
        send_byte(8'hFF);

        // random phases, each under its own chunk size
        phase_no = 0;
        while (sb.n_bytes < ITEMS) begin
            settle();
            case (phase_no)
                0: size_pick = 24'd1;
                1: size_pick = MAX24;
                2: size_pick = 24'd2;
                3: size_pick = INIT_CHUNK_SIZE;
                default: size_pick = ($urandom_range(5) == 0) ? MAX24 : $urandom_range(24, 1);
            endcase
            write_chunk_size(size_pick);
            calm    = (phase_no == 4);
            stop_at = sb.n_bytes + PHASE_LEN;
            while (sb.n_bytes < stop_at) send_random_message();
            phase_no++;
        end
        calm = 1'b0;
        settle();
        halt_block();
        settle();

        if (sb.due.size() != 0) begin
            $display("%0d predicted results never arrived", sb.due.size());
            sb.fails += sb.due.size();
        end
        $display("summary: %0d bytes over %0d chunk-size settings, %0d in-band size changes",
                 sb.n_bytes, cfg_writes, sb.n_resize);
        $display("summary: %0d payload bytes, %0d empty markers, %0d error results, %0d failures",
                 sb.n_payload, sb.n_marker, sb.n_error, sb.fails);
        if (sb.fails == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
